// ----- hw/rtl/bcr_pkg.sv -----
// shared constants and elaboration-time helpers for the brooks-corey block
package bcr_pkg;

  localparam int BCR_FRAC_BITS = 16;

  // exponent format and the q0.32 power datapath
  localparam int EXP_W    = 16;
  localparam int Q32_W    = 32;
  localparam int LOG_BITS = 28;
  localparam int IP_W     = 10;
  localparam int LG_W     = 34;

  localparam logic [EXP_W-1:0] EXP_RESET = 16'd8192;

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_IRR_SAT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WET_EXP  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NWET_EXP = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WET_END  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NWET_END = 3'd4;

  // divider: quotient bits resolved per stage
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = Q32_W / DIV_BITS_PER_STAGE;

  // power unit latency: normalize, squarings, product, exp steps, final shift
  localparam int POW_LAT = 1 + LOG_BITS + 1 + LOG_BITS + 1;

  // power special-case codes
  localparam logic [1:0] SPC_NONE = 2'd0;
  localparam logic [1:0] SPC_ONE  = 2'd1;
  localparam logic [1:0] SPC_ZERO = 2'd2;

  // integer square root, bit by bit
  function automatic logic [63:0] bcr_isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > v) begin
        bitv = bitv >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 64'd0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // 2^(-2^-k) in q0.32, k = 1..LOG_BITS
  function automatic logic [31:0] bcr_exp_coef(input int k);
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int j = 1; j <= LOG_BITS; j++) begin
      if (j <= k) begin
        t = bcr_isqrt(t << 32);
      end
    end
    return t[31:0];
  endfunction

endpackage

// ----- hw/rtl/bcr_pow.sv -----
// pipelined q0.32 power unit through log2 and exp2
module bcr_pow import bcr_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Q32_W:0]   x_i,
  input  logic [EXP_W-1:0] e_i,
  output logic [Q32_W:0]   r_o
);

  typedef struct packed {
    logic [1:0]          spc;
    logic [4:0]          p;
    logic [30:0]         m;
    logic [LOG_BITS-1:0] frac;
  } sq_t;

  typedef struct packed {
    logic [1:0]          spc;
    logic [IP_W-1:0]     ip;
    logic [LOG_BITS-1:0] f;
    logic [Q32_W:0]      r;
  } ex_t;

  sq_t sq_q [0:LOG_BITS];
  ex_t ex_q [0:LOG_BITS];
  logic [Q32_W:0] r_q;

  // normalize: leading one to bit 30
  logic [1:0]  nrm_spc;
  logic [4:0]  nrm_p;
  logic [31:0] nrm_sh;

  always_comb begin
    nrm_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x_i[i]) begin
        nrm_p = 5'(i);
      end
    end
    nrm_sh = x_i[31:0] << (5'd31 - nrm_p);
    if (e_i == '0) begin
      nrm_spc = SPC_ONE;
    end else if (x_i == '0) begin
      nrm_spc = SPC_ZERO;
    end else if (x_i[Q32_W]) begin
      nrm_spc = SPC_ONE;
    end else begin
      nrm_spc = SPC_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0].spc  <= nrm_spc;
      sq_q[0].p    <= nrm_p;
      sq_q[0].m    <= nrm_sh[31:1];
      sq_q[0].frac <= '0;
    end
  end

  // one squaring per stage, one log2 fraction bit each
  for (genvar i = 1; i <= LOG_BITS; i++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    sq_t         nxt;
    always_comb begin
      sq  = sq_q[i-1].m * sq_q[i-1].m;
      t   = sq[61:30];
      nxt = sq_q[i-1];
      if (t[31]) begin
        nxt.m                 = t[31:1];
        nxt.frac[LOG_BITS-i]  = 1'b1;
      end else begin
        nxt.m = t[30:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[i] <= nxt;
      end
    end
  end

  // -log2(x) times exponent, split into integer and fraction
  logic [LG_W-1:0]       lg;
  logic [LG_W+EXP_W-1:0] prod;

  always_comb begin
    lg   = {6'(6'd32 - {1'b0, sq_q[LOG_BITS].p}), {LOG_BITS{1'b0}}}
           - LG_W'(sq_q[LOG_BITS].frac);
    prod = lg * e_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q[0].spc <= sq_q[LOG_BITS].spc;
      ex_q[0].ip  <= prod[LG_W+EXP_W-1 -: IP_W];
      ex_q[0].f   <= prod[EXP_W-4 +: LOG_BITS];
      ex_q[0].r   <= {1'b1, {Q32_W{1'b0}}};
    end
  end

  // one conditional multiply by a root coefficient per stage
  for (genvar k = 1; k <= LOG_BITS; k++) begin : g_ex
    localparam logic [31:0] COEF = bcr_exp_coef(k);
    logic [64:0] mul;
    ex_t         nxt;
    always_comb begin
      mul = ex_q[k-1].r * COEF;
      nxt = ex_q[k-1];
      if (ex_q[k-1].f[LOG_BITS-k]) begin
        nxt.r = mul[64:32];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ex_q[k] <= nxt;
      end
    end
  end

  // integer part as a right shift, special cases resolved
  logic [Q32_W:0] r_d;

  always_comb begin
    if (ex_q[LOG_BITS].spc == SPC_ONE) begin
      r_d = {1'b1, {Q32_W{1'b0}}};
    end else if (ex_q[LOG_BITS].spc == SPC_ZERO) begin
      r_d = '0;
    end else if (|ex_q[LOG_BITS].ip[IP_W-1:6]) begin
      r_d = '0;
    end else begin
      r_d = ex_q[LOG_BITS].r >> ex_q[LOG_BITS].ip[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

// ----- hw/rtl/brooks_corey_relperm.sv -----
// top level: brooks-corey relative permeability pipeline
//
// usage
// - input channel: one wetting saturation (q1.FRAC_BITS) per transaction on
//   in_valid_i / in_ready_o; output channel: wetting and non-wetting relative
//   permeability (q1.FRAC_BITS) per transaction on out_valid_o / out_ready_i
// - config channel: cfg_index_i selects the register (irreducible saturation,
//   wet exponent, non-wet exponent, wet endpoint, non-wet endpoint), written
//   when cfg_valid_i is high; cfg_ready_o is always high; unknown indexes drop
// - pipeline: one input stage, 8 divider stages of 4 quotient
//   bits each, a 59-stage power unit (one normalize, 28 squarings for log2,
//   one product, 28 root multiplies for exp2, one shift) and the output
//   register
// - throughput is one transaction per cycle while the output is not held;
//   the wet and non-wet powers run in two parallel power units
// - while the output holds a result that is not taken, the whole pipeline
//   holds and in_ready_o is low; nothing is lost or repeated
// - reset clears all stage valids and loads the register reset values
module brooks_corey_relperm import bcr_pkg::*; #(
  parameter int FRAC_BITS = BCR_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FRAC_BITS:0]    wet_saturation_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FRAC_BITS:0]    wet_relperm_o,
  output logic [FRAC_BITS:0]    nonwet_relperm_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [REG_IDX_W-1:0]  cfg_index_i,
  input  logic [((FRAC_BITS + 1 > EXP_W) ? FRAC_BITS : EXP_W - 1):0] cfg_data_i
);

  localparam int RW = FRAC_BITS + 1;
  localparam int PW = Q32_W + RW + 1;
  localparam logic [RW-1:0] SAT_ONE = RW'(1) << FRAC_BITS;
  localparam logic [Q32_W:0] Q32_ONE = {1'b1, {Q32_W{1'b0}}};

  // configuration registers
  logic [FRAC_BITS-1:0] irr_q;
  logic [EXP_W-1:0]     wexp_q, nexp_q;
  logic [RW-1:0]        wend_q, nend_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irr_q  <= '0;
      wexp_q <= EXP_RESET;
      nexp_q <= EXP_RESET;
      wend_q <= SAT_ONE;
      nend_q <= SAT_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IRR_SAT:  irr_q  <= cfg_data_i[FRAC_BITS-1:0];
        REG_WET_EXP:  wexp_q <= cfg_data_i[EXP_W-1:0];
        REG_NWET_EXP: nexp_q <= cfg_data_i[EXP_W-1:0];
        REG_WET_END:  wend_q <= cfg_data_i[FRAC_BITS:0];
        REG_NWET_END: nend_q <= cfg_data_i[FRAC_BITS:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a result is stuck at the output
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // divider stage payload
  typedef struct packed {
    logic          low;
    logic          sat;
    logic [RW-1:0] den;
    logic [RW-1:0] rem;
    logic [31:0]   quo;
  } dv_t;

  logic dv_vld_q [0:DIV_STAGES];
  dv_t  dv_q     [0:DIV_STAGES];

  // input stage: numerator, denominator and the range flags
  logic [RW-1:0] num, den;
  logic          low, sat;

  always_comb begin
    low = wet_saturation_i <= {1'b0, irr_q};
    num = wet_saturation_i - {1'b0, irr_q};
    den = SAT_ONE - {1'b0, irr_q};
    sat = num >= den;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].low <= low;
      dv_q[0].sat <= sat;
      dv_q[0].den <= den;
      dv_q[0].rem <= (low || sat) ? '0 : num;
      dv_q[0].quo <= '0;
    end
  end

  // restoring division, DIV_BITS_PER_STAGE quotient bits per stage
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    dv_t       nxt;
    logic [RW:0] t;
    always_comb begin
      nxt = dv_q[j-1];
      t   = '0;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        t = {nxt.rem, 1'b0};
        if (t >= {1'b0, nxt.den}) begin
          nxt.rem = RW'(t - {1'b0, nxt.den});
          nxt.quo = {nxt.quo[30:0], 1'b1};
        end else begin
          nxt.rem = t[RW-1:0];
          nxt.quo = {nxt.quo[30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j] <= nxt;
      end
    end
  end

  for (genvar j = 0; j <= DIV_STAGES; j++) begin : g_dv_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j] <= (j == 0) ? in_valid_i : dv_vld_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // effective saturation and its complement in q0.32
  logic [Q32_W:0] s_x, s_y;
  logic [Q32_W:0] pw_wet, pw_nwet;

  assign s_x = dv_q[DIV_STAGES].sat ? Q32_ONE : {1'b0, dv_q[DIV_STAGES].quo};
  assign s_y = Q32_ONE - s_x;

  bcr_pow u_pow_wet (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (s_x),
    .e_i   (wexp_q),
    .r_o   (pw_wet)
  );

  bcr_pow u_pow_nwet (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (s_y),
    .e_i   (nexp_q),
    .r_o   (pw_nwet)
  );

  // sideband that runs alongside the power units
  logic pl_vld_q [0:POW_LAT-1];
  logic pl_low_q [0:POW_LAT-1];

  for (genvar j = 0; j < POW_LAT; j++) begin : g_pl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pl_vld_q[j] <= 1'b0;
      end else if (en) begin
        pl_vld_q[j] <= (j == 0) ? dv_vld_q[DIV_STAGES] : pl_vld_q[(j == 0) ? 0 : j - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        pl_low_q[j] <= (j == 0) ? dv_q[DIV_STAGES].low : pl_low_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // endpoint scaling with rounding, endpoints clamped to one
  logic [RW-1:0]          wend_c, nend_c;
  logic [Q32_W+RW:0]      wprod, nprod;
  logic [RW-1:0]          kw_d, knw_d;

  always_comb begin
    wend_c = (wend_q > SAT_ONE) ? SAT_ONE : wend_q;
    nend_c = (nend_q > SAT_ONE) ? SAT_ONE : nend_q;
    wprod  = PW'(pw_wet[Q32_W-1:0]) * PW'(wend_c) + PW'(Q32_ONE >> 1);
    nprod  = PW'(pw_nwet[Q32_W-1:0]) * PW'(nend_c) + PW'(Q32_ONE >> 1);
    if (pl_low_q[POW_LAT-1]) begin
      kw_d  = '0;
      knw_d = nend_c;
    end else begin
      kw_d  = pw_wet[Q32_W]  ? wend_c : wprod[Q32_W +: RW];
      knw_d = pw_nwet[Q32_W] ? nend_c : nprod[Q32_W +: RW];
    end
  end

  // output register
  logic [RW-1:0] kw_q, knw_q;
  logic          out_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pl_vld_q[POW_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kw_q      <= kw_d;
      knw_q     <= knw_d;
      out_low_q <= pl_low_q[POW_LAT-1];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign wet_relperm_o    = kw_q;
  assign nonwet_relperm_o = knw_q;

  // results never exceed one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wet_relperm_o <= SAT_ONE) && (nonwet_relperm_o <= SAT_ONE))
    else $error("relperm result above one");

  // at or below irreducible saturation the wetting phase does not flow
  a_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_low_q) |-> (wet_relperm_o == '0) && (nonwet_relperm_o == nend_c))
    else $error("low saturation result wrong");

  // a held output freezes the pipeline valids
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      $stable(pl_vld_q[POW_LAT-1]) && $stable(dv_vld_q[DIV_STAGES]) && $stable(dv_vld_q[0]))
    else $error("pipeline moved during stall");

endmodule
